FILE: rtl/pfp_pkg.sv
// Package for the particle sensor frame parser: sizes, check words, status codes.
package pfp_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int MEAS_WORDS  = 12;

  localparam logic [15:0] HEADER_WORD = 16'h424D;
  localparam logic [15:0] LENGTH_WORD = 16'h001C;
  localparam logic [ADDR_W-1:0] SUM_END = ADDR_W'(30);

  // Request kinds on the input channel
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_GAP  = 1'b1;

  // Word slots walked by the sequencer: header, length, checksum, then the measurements
  localparam logic [3:0] W_HEADER = 4'd0;
  localparam logic [3:0] W_LENGTH = 4'd1;
  localparam logic [3:0] W_CHKSUM = 4'd2;
  localparam logic [3:0] W_MEAS0  = 4'd3;
  localparam logic [3:0] W_LASTW  = 4'(3 + MEAS_WORDS - 1);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
  localparam logic [2:0] ST_BAD_SUM    = 3'd3;
  localparam logic [2:0] ST_SHORT      = 3'd4;

  // Byte offset of the high byte of a word slot
  function automatic logic [ADDR_W-1:0] word_off(input logic [3:0] w);
    logic [ADDR_W-1:0] off;
    case (w)
      W_HEADER: off = ADDR_W'(0);
      W_LENGTH: off = ADDR_W'(2);
      W_CHKSUM: off = SUM_END;
      default:  off = ADDR_W'({1'b0, w} << 1) - ADDR_W'(2);
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/particle_sensor_frame_parser.sv
// Particle sensor frame parser: byte capture, sequenced frame check and word output.
//
// Input channel (in_valid/in_ready): each request carries kind and rx_byte.
// kind 0 stores a received byte (the first 32 of a frame) and adds bytes 0 to 29
// to a 16-bit sum; in_ready stays high after it.
// kind 1 is the idle gap closing the frame. On an empty frame it does nothing.
// A short frame yields a single ST_SHORT status request. For a full frame the
// sequencer walks the frame store, reading one byte at a time from its single
// read port and building each big-endian word from its high and low byte, and a
// single shared comparator checks header, length and checksum in turn. A bad
// header, length or checksum yields one status request for it; a good frame
// yields 12 measurement requests.
// in_ready stays low until the frame is done.
// Output channel (out_valid/out_ready): one registered request stage. If the
// receiver stalls, the sequencer waits with the next word until the stage
// frees. Byte requests are still taken while a result waits to be collected.
// Reset (rst, synchronous) clears the state, the count, the sum and out_valid;
// the frame store and the output data are not cleared.
module particle_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  measure_index,
  output logic [15:0] measure_value,
  output logic        last
);
  import pfp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HI   = 2'd1;
  localparam logic [1:0] S_LO   = 2'd2;
  localparam logic [1:0] S_USE  = 2'd3;

  logic [1:0]         state, state_next;
  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        running_sum;
  logic [3:0]         wsel;
  logic [7:0]         hi_byte;
  logic [7:0]         rd_data;
  logic [7:0]         frame_store [FRAME_BYTES];

  logic              in_fire;
  logic              out_free;
  logic              full;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       word;
  logic [15:0]       cmp_ref;
  logic              mismatch;
  logic              finish;
  logic              load;
  logic [2:0]        load_status;
  logic [3:0]        load_index;
  logic [15:0]       load_value;
  logic              load_last;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign full     = (byte_count == COUNT_W'(FRAME_BYTES));
  assign word     = {hi_byte, rd_data};

  // Store port: writes while capturing, reads while sequencing
  assign rd_en   = (state == S_HI) || (state == S_LO);
  assign rd_addr = (state == S_LO) ? (word_off(wsel) | ADDR_W'(1)) : word_off(wsel);

  always_ff @(posedge clk) begin
    if (in_fire && (kind == KIND_BYTE) && !full) begin
      frame_store[byte_count[ADDR_W-1:0]] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // Shared comparator: reference word picked by the slot under check
  always_comb begin
    case (wsel)
      W_HEADER: cmp_ref = HEADER_WORD;
      W_LENGTH: cmp_ref = LENGTH_WORD;
      default:  cmp_ref = running_sum;
    endcase
  end
  assign mismatch = (word != cmp_ref);

  // Sequencer decisions: frame start in idle, then the high, low and word-use steps
  always_comb begin
    state_next  = state;
    finish      = 1'b0;
    load        = 1'b0;
    load_status = ST_OK;
    load_index  = '0;
    load_value  = '0;
    load_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_fire && (kind == KIND_GAP) && (byte_count != '0)) begin
          state_next = full ? S_HI : S_USE;
        end
      end
      S_HI: state_next = S_LO;
      S_LO: state_next = S_USE;
      S_USE: begin
        if (!full) begin
          if (out_free) begin
            load        = 1'b1;
            load_status = ST_SHORT;
            finish      = 1'b1;
          end
        end else if (wsel < W_MEAS0) begin
          if (mismatch) begin
            if (out_free) begin
              load   = 1'b1;
              finish = 1'b1;
              case (wsel)
                W_HEADER: load_status = ST_BAD_HEADER;
                W_LENGTH: load_status = ST_BAD_LENGTH;
                default:  load_status = ST_BAD_SUM;
              endcase
            end
          end else begin
            state_next = S_HI;
          end
        end else if (out_free) begin
          load       = 1'b1;
          load_index = wsel - W_MEAS0;
          load_value = word;
          load_last  = (wsel == W_LASTW);
          finish     = load_last;
          state_next = S_HI;
        end
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control: state, count, sum, word slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_count  <= '0;
      running_sum <= '0;
      wsel        <= W_HEADER;
    end else begin
      state <= state_next;
      if (in_fire && (kind == KIND_BYTE) && !full) begin
        byte_count <= byte_count + COUNT_W'(1);
        if (byte_count[ADDR_W-1:0] < SUM_END) begin
          running_sum <= running_sum + {8'd0, rx_byte};
        end
      end
      if (state == S_IDLE) begin
        wsel <= W_HEADER;
      end else if (state == S_USE && state_next == S_HI) begin
        wsel <= wsel + 4'd1;
      end
      if (finish) begin
        byte_count  <= '0;
        running_sum <= '0;
      end
    end
  end

  // High byte latch: read data of the high byte arrives in the low-byte step
  always_ff @(posedge clk) begin
    if (state == S_LO) begin
      hi_byte <= rd_data;
    end
  end

  // Output request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= load_status;
      measure_index <= load_index;
      measure_value <= load_value;
      last          <= load_last;
    end
  end

endmodule

FILE: tb/sv/particle_sensor_frame_parser_tb.sv
// Self-checking testbench for the particle sensor frame parser.
module particle_sensor_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfp_pkg::*;

  localparam int RUN_LIMIT     = 200000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 60;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  measure_index;
  logic [15:0] measure_value;
  logic        last;

  // predictor copy of the parser state
  int unsigned   shadow_count = 0;
  logic [15:0]   shadow_sum = '0;
  logic [7:0]    shadow_store [FRAME_BYTES];
  frame_result_t pending_results [$];
  frame_result_t due_result;

  // frame under construction by the stimulus
  logic [7:0] tx_frame [FRAME_BYTES];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int failures           = 0;
  int sent_requests      = 0;
  int checked_results    = 0;
  int good_frames        = 0;
  int rejected_frames    = 0;
  int cycle_count        = 0;

  particle_sensor_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .measure_index (measure_index),
    .measure_value (measure_value),
    .last          (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // big-endian word from the shadow store
  function automatic logic [15:0] stored_word(input int off);
    return {shadow_store[off], shadow_store[off + 1]};
  endfunction

  // capture a byte or close the frame, queueing the results it causes
  task automatic predict_request(input logic req_kind, input logic [7:0] req_byte);
    logic [2:0]    verdict;
    frame_result_t r;
    int            w;
    if (req_kind == KIND_BYTE) begin
      if (shadow_count < FRAME_BYTES) begin
        shadow_store[shadow_count] = req_byte;
        if (shadow_count < SUM_END) shadow_sum = shadow_sum + 16'(req_byte);
        shadow_count++;
      end
    end else if (shadow_count != 0) begin
      if (shadow_count < FRAME_BYTES) verdict = ST_SHORT;
      else if (stored_word(0) != HEADER_WORD) verdict = ST_BAD_HEADER;
      else if (stored_word(2) != LENGTH_WORD) verdict = ST_BAD_LENGTH;
      else if (stored_word(SUM_END) != shadow_sum) verdict = ST_BAD_SUM;
      else verdict = ST_OK;
      shadow_count = 0;
      shadow_sum = '0;
      if (verdict != ST_OK) begin
        r.status = verdict;
        r.index  = '0;
        r.value  = '0;
        r.last   = 1'b1;
        pending_results.push_back(r);
        rejected_frames++;
      end else begin
        for (w = 0; w < MEAS_WORDS; w++) begin
          r.status = ST_OK;
          r.index  = 4'(w);
          r.value  = stored_word(4 + 2 * w);
          r.last   = (w == MEAS_WORDS - 1);
          pending_results.push_back(r);
        end
        good_frames++;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected request: status %0d index %0d value %h last %0d",
               status, measure_index, measure_value, last);
        failures++;
      end else begin
        due_result = pending_results.pop_front();
        checked_results++;
        if (status !== due_result.status) begin
          $error("status: expected %0d, got %0d", due_result.status, status);
          failures++;
        end
        if (measure_index !== due_result.index) begin
          $error("measure_index: expected %0d, got %0d", due_result.index, measure_index);
          failures++;
        end
        if (measure_value !== due_result.value) begin
          $error("measure_value: expected %h, got %h", due_result.value, measure_value);
          failures++;
        end
        if (last !== due_result.last) begin
          $error("last: expected %0d, got %0d", due_result.last, last);
          failures++;
        end
      end
    end
  end

  // one input request, with random idle cycles ahead of it
  task automatic send_request(input logic req_kind, input logic [7:0] req_byte);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= req_kind;
    rx_byte  <= req_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req_kind, req_byte);
    sent_requests++;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // hold off the sender until every queued result is in
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // recompute the checksum word over bytes 0 to 29
  task automatic seal_checksum();
    logic [15:0] s;
    int          i;
    s = '0;
    for (i = 0; i < SUM_END; i++) s = s + 16'(tx_frame[i]);
    tx_frame[SUM_END]     = s[15:8];
    tx_frame[SUM_END + 1] = s[7:0];
  endtask

  // well-formed frame with random measurement bytes
  task automatic load_frame();
    int i;
    tx_frame[0] = HEADER_WORD[15:8];
    tx_frame[1] = HEADER_WORD[7:0];
    tx_frame[2] = LENGTH_WORD[15:8];
    tx_frame[3] = LENGTH_WORD[7:0];
    for (i = 4; i < SUM_END; i++) tx_frame[i] = 8'($urandom_range(255));
    seal_checksum();
  endtask

  task automatic flip_frame_bit(input int lo, input int hi);
    int idx;
    idx = $urandom_range(hi, lo);
    tx_frame[idx] = tx_frame[idx] ^ 8'(1 << $urandom_range(7));
  endtask

  // send n bytes (random filler past the frame size) and then the closing gap
  task automatic send_frame(input int n_bytes);
    int i;
    for (i = 0; i < n_bytes; i++)
      send_request(KIND_BYTE, (i < FRAME_BYTES) ? tx_frame[i] : 8'($urandom_range(255)));
    send_request(KIND_GAP, 8'($urandom_range(255)));
  endtask

  // gap on an empty frame, both rx_byte extremes
  task automatic test_empty_gap();
    send_request(KIND_GAP, 8'h00);
    send_request(KIND_GAP, 8'hFF);
  endtask

  // good frame with extreme measurement words
  task automatic test_good_frame();
    load_frame();
    tx_frame[4]  = 8'hFF; tx_frame[5]  = 8'hFF;
    tx_frame[6]  = 8'h00; tx_frame[7]  = 8'h00;
    tx_frame[8]  = 8'h80; tx_frame[9]  = 8'h01;
    tx_frame[10] = 8'h7F; tx_frame[11] = 8'hFE;
    tx_frame[26] = 8'hA5; tx_frame[27] = 8'h5A;
    seal_checksum();
    send_frame(FRAME_BYTES);
  endtask

  // one byte, and one byte short of a full frame
  task automatic test_short_frames();
    tx_frame[0] = 8'hFF;
    send_frame(1);
    load_frame();
    send_frame(FRAME_BYTES - 1);
  endtask

  task automatic test_bad_header();
    load_frame();
    tx_frame[1] = 8'h4C;
    seal_checksum();
    send_frame(FRAME_BYTES);
  endtask

  task automatic test_bad_length();
    load_frame();
    tx_frame[2] = 8'h80;
    seal_checksum();
    send_frame(FRAME_BYTES);
  endtask

  task automatic test_bad_checksum();
    load_frame();
    tx_frame[SUM_END + 1] = tx_frame[SUM_END + 1] ^ 8'h01;
    send_frame(FRAME_BYTES);
  endtask

  // bytes past the frame size must not disturb a good frame
  task automatic test_overlong_frame();
    load_frame();
    send_frame(FRAME_BYTES + 3);
  endtask

  // mostly good frames, the rest corrupted, cut short, overlong, noise or a lone gap
  task automatic test_random_frames(input int item_budget);
    int taken;
    int pick;
    int n;
    taken = 0;
    while (taken < item_budget) begin
      pick = $urandom_range(99);
      n = FRAME_BYTES;
      load_frame();
      if (pick < 55) begin
      end else if (pick < 62) begin
        flip_frame_bit(0, 1);
        seal_checksum();
      end else if (pick < 69) begin
        flip_frame_bit(2, 3);
        seal_checksum();
      end else if (pick < 78) begin
        flip_frame_bit(4, SUM_END + 1);
      end else if (pick < 86) begin
        n = $urandom_range(FRAME_BYTES - 1, 1);
      end else if (pick < 92) begin
        n = $urandom_range(FRAME_BYTES + 8, FRAME_BYTES + 1);
      end else if (pick < 97) begin
        foreach (tx_frame[i]) tx_frame[i] = 8'($urandom_range(255));
        n = $urandom_range(FRAME_BYTES + 8, 1);
      end else begin
        n = 0;
      end
      send_frame(n);
      if (n != 0) taken += ((n < FRAME_BYTES) ? n : FRAME_BYTES) + 1;
    end
  endtask

  initial begin
    set_idling(29, 59);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_gap();
    test_good_frame();
    test_short_frames();
    test_bad_header();
    test_bad_length();
    test_bad_checksum();
    test_overlong_frame();
    wait_results_drained();

    test_random_frames(PHASE_ITEMS);
    wait_results_drained();
    set_idling(59, 29);
    test_random_frames(PHASE_ITEMS);
    wait_results_drained();
    set_idling(0, 0);
    test_random_frames(PHASE_ITEMS);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failures++;
    end

    $display("run covered %0d input requests and %0d checked results in %0d cycles",
             sent_requests, checked_results, cycle_count);
    $display("frames: %0d good, %0d rejected; %0d mismatches",
             good_frames, rejected_frames, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
